FILE: rtl/core/tqc_pkg.sv
package tqc_pkg;

    // Queue geometry.
    localparam int DEPTH         = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);

    // Fixed widths of the port fields.
    localparam int PORT_PAY_W = 32;
    localparam int TAG_W      = 31;
    localparam int OCC_W      = 5;

    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ENQ    = 2'd0,
        CMD_DEQ    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_FOUND    = 2'd1,
        ST_FULL         = 2'd2,
        ST_ZERO_PAYLOAD = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                  command;
        logic [PORT_PAY_W-1:0] payload_in;
        logic [TAG_W-1:0]      target_tag;
    } in_t;

    typedef struct packed {
        status_t               status;
        logic [TAG_W-1:0]      tag_out;
        logic [PORT_PAY_W-1:0] payload_out;
        logic [OCC_W-1:0]      occupancy;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_DEQ,
        S_SEARCH,
        S_RESP
    } state_t;

    // Which result the datapath captures.
    typedef enum logic [2:0] {
        RK_ENQ,
        RK_DEQ,
        RK_REMOVE,
        RK_GET,
        RK_EMPTY,
        RK_FULL,
        RK_ZERO
    } res_kind_t;

    // Source of the slot memory read address.
    typedef enum logic [1:0] {
        RD_CUR,
        RD_HEAD,
        RD_TAIL,
        RD_PREV
    } rd_sel_t;

    typedef struct packed {
        logic      latch;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      step_clr;
        logic      do_enq;
        logic      do_unlink;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic pay_zero;
        logic full;
        logic empty;
        logic tgt_zero;
        logic tag_match;
        logic search_last;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/core/tqc_datapath.sv
module tqc_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  tqc_pkg::in_t   in_data,
    input  tqc_pkg::ctrl_t ctrl,
    input  logic           out_ready,
    output tqc_pkg::stat_t stat,
    output tqc_pkg::out_t  out_data,
    output logic           out_valid
);

    // Lowest-numbered unused slot.
    function automatic logic [tqc_pkg::IDX_W-1:0] lowest_free(
        input logic [tqc_pkg::DEPTH-1:0] used
    );
        logic [tqc_pkg::IDX_W-1:0] idx;
        idx = '0;
        for (int i = tqc_pkg::DEPTH - 1; i >= 0; i--) begin
            if (!used[i]) begin
                idx = tqc_pkg::IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Slot memories.
    logic [tqc_pkg::PAYLOAD_WIDTH-1:0] slot_pay_mem  [tqc_pkg::DEPTH];
    logic [tqc_pkg::TAG_W-1:0]         slot_tag_mem  [tqc_pkg::DEPTH];
    logic [tqc_pkg::IDX_W-1:0]         slot_next_mem [tqc_pkg::DEPTH];
    logic [tqc_pkg::IDX_W-1:0]         slot_prev_mem [tqc_pkg::DEPTH];

    logic [tqc_pkg::PAYLOAD_WIDTH-1:0] rd_pay_reg;
    logic [tqc_pkg::TAG_W-1:0]         rd_tag_reg;
    logic [tqc_pkg::IDX_W-1:0]         rd_next_reg;
    logic [tqc_pkg::IDX_W-1:0]         rd_prev_reg;

    // Latched command.
    tqc_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [tqc_pkg::PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [tqc_pkg::TAG_W-1:0]         tgt_reg, tgt_next;

    // List control state.
    logic [tqc_pkg::IDX_W-1:0] head_reg, head_next;
    logic [tqc_pkg::IDX_W-1:0] tail_reg, tail_next;
    logic [tqc_pkg::IDX_W-1:0] cur_reg, cur_next;
    logic [tqc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [tqc_pkg::CNT_W-1:0] step_reg, step_next;
    logic [tqc_pkg::TAG_W-1:0] last_tag_reg, last_tag_next;
    logic [tqc_pkg::DEPTH-1:0] used_reg, used_next;

    // Result and output registers.
    tqc_pkg::status_t                  res_status_reg, res_status_next;
    logic [tqc_pkg::TAG_W-1:0]         res_tag_reg, res_tag_next;
    logic [tqc_pkg::PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    tqc_pkg::out_t                     out_reg, out_next;
    logic                              out_valid_reg, out_valid_next;

    logic [tqc_pkg::IDX_W-1:0] free_slot;
    logic [tqc_pkg::TAG_W-1:0] tag_new;
    logic [tqc_pkg::IDX_W-1:0] rd_addr;
    logic                      next_we, prev_we;
    logic [tqc_pkg::IDX_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

    assign free_slot = lowest_free(used_reg);
    assign tag_new   = (last_tag_reg == '0 || last_tag_reg == tqc_pkg::TAG_MAX)
                     ? tqc_pkg::TAG_W'(1) : last_tag_reg + tqc_pkg::TAG_W'(1);

    // Read address of the slot memories.
    always_comb begin
        unique case (ctrl.rd_sel)
            tqc_pkg::RD_HEAD: rd_addr = head_reg;
            tqc_pkg::RD_TAIL: rd_addr = tail_reg;
            tqc_pkg::RD_PREV: rd_addr = rd_prev_reg;
            default:          rd_addr = cur_reg;
        endcase
    end

    // Link writes for append and unlink.
    always_comb begin
        next_we = 1'b0;
        next_wa = tail_reg;
        next_wd = free_slot;
        prev_we = 1'b0;
        prev_wa = free_slot;
        prev_wd = tail_reg;
        if (ctrl.do_enq) begin
            next_we = (count_reg != '0);
            prev_we = 1'b1;
        end else if (ctrl.do_unlink) begin
            next_we = (cur_reg != head_reg);
            next_wa = rd_prev_reg;
            next_wd = rd_next_reg;
            prev_we = (cur_reg != tail_reg);
            prev_wa = rd_next_reg;
            prev_wd = rd_prev_reg;
        end
    end

    // Slot memories with registered read.
    always_ff @(posedge aclk) begin
        if (ctrl.do_enq) begin
            slot_pay_mem[free_slot] <= pay_reg;
            slot_tag_mem[free_slot] <= tag_new;
        end
        if (next_we) begin
            slot_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            slot_prev_mem[prev_wa] <= prev_wd;
        end
        if (ctrl.rd_en) begin
            rd_pay_reg  <= slot_pay_mem[rd_addr];
            rd_tag_reg  <= slot_tag_mem[rd_addr];
            rd_next_reg <= slot_next_mem[rd_addr];
            rd_prev_reg <= slot_prev_mem[rd_addr];
        end
    end

    // Command latch, read pointer and walk counter.
    always_comb begin
        cmd_next  = cmd_reg;
        pay_next  = pay_reg;
        tgt_next  = tgt_reg;
        cur_next  = cur_reg;
        step_next = step_reg;
        if (ctrl.latch) begin
            cmd_next = in_data.command;
            pay_next = in_data.payload_in[tqc_pkg::PAYLOAD_WIDTH-1:0];
            tgt_next = in_data.target_tag;
        end
        if (ctrl.rd_en) begin
            cur_next = rd_addr;
            if (ctrl.step_clr) begin
                step_next = '0;
            end else if (ctrl.rd_sel == tqc_pkg::RD_PREV) begin
                step_next = step_reg + tqc_pkg::CNT_W'(1);
            end
        end
    end

    // List bookkeeping for append and unlink.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        last_tag_next = last_tag_reg;
        used_next     = used_reg;
        if (ctrl.do_enq) begin
            used_next[free_slot] = 1'b1;
            if (count_reg == '0) begin
                head_next = free_slot;
            end
            tail_next     = free_slot;
            count_next    = count_reg + tqc_pkg::CNT_W'(1);
            last_tag_next = tag_new;
        end else if (ctrl.do_unlink) begin
            used_next[cur_reg] = 1'b0;
            if (cur_reg == head_reg) begin
                head_next = rd_next_reg;
            end
            if (cur_reg == tail_reg) begin
                tail_next = rd_prev_reg;
            end
            count_next = count_reg - tqc_pkg::CNT_W'(1);
            if (count_reg == tqc_pkg::CNT_W'(1)) begin
                head_next = '0;
                tail_next = '0;
            end
        end
    end

    // Result capture.
    always_comb begin
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_pay_next    = res_pay_reg;
        if (ctrl.res_load) begin
            res_status_next = tqc_pkg::ST_OK;
            res_tag_next    = '0;
            res_pay_next    = '0;
            unique case (ctrl.res_kind)
                tqc_pkg::RK_ENQ: begin
                    res_tag_next = tag_new;
                end
                tqc_pkg::RK_DEQ: begin
                    res_tag_next = rd_tag_reg;
                    res_pay_next = rd_pay_reg;
                end
                tqc_pkg::RK_REMOVE: begin
                    res_tag_next = tgt_reg;
                end
                tqc_pkg::RK_GET: begin
                    res_tag_next = tgt_reg;
                    res_pay_next = rd_pay_reg;
                end
                tqc_pkg::RK_FULL: begin
                    res_status_next = tqc_pkg::ST_FULL;
                end
                tqc_pkg::RK_ZERO: begin
                    res_status_next = tqc_pkg::ST_ZERO_PAYLOAD;
                end
                default: begin
                    res_status_next = tqc_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Output register; a new result loads when the old one is gone.
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (ctrl.out_load) begin
            out_next.status      = res_status_reg;
            out_next.tag_out     = res_tag_reg;
            out_next.payload_out = tqc_pkg::PORT_PAY_W'(res_pay_reg);
            out_next.occupancy   = tqc_pkg::OCC_W'(count_reg);
            out_valid_next       = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        pay_reg        <= pay_next;
        tgt_reg        <= tgt_next;
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_pay_reg    <= res_pay_next;
        out_reg        <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            last_tag_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            last_tag_reg  <= last_tag_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Status toward the controller.
    always_comb begin
        stat.cmd         = cmd_reg;
        stat.pay_zero    = (pay_reg == '0);
        stat.full        = (count_reg == tqc_pkg::CNT_W'(tqc_pkg::DEPTH));
        stat.empty       = (count_reg == '0);
        stat.tgt_zero    = (tgt_reg == '0);
        stat.tag_match   = used_reg[cur_reg] && (rd_tag_reg == tgt_reg);
        stat.search_last = ((step_reg + tqc_pkg::CNT_W'(1)) == count_reg);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/tqc_ctrl.sv
module tqc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  tqc_pkg::stat_t stat,
    output logic           in_ready,
    output tqc_pkg::ctrl_t ctrl
);

    tqc_pkg::state_t state_reg, state_next;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tqc_pkg::S_IDLE: begin
                if (in_valid) begin
                    state_next = tqc_pkg::S_DISPATCH;
                end
            end
            tqc_pkg::S_DISPATCH: begin
                unique case (stat.cmd)
                    tqc_pkg::CMD_ENQ: begin
                        state_next = tqc_pkg::S_RESP;
                    end
                    tqc_pkg::CMD_DEQ: begin
                        state_next = stat.empty ? tqc_pkg::S_RESP : tqc_pkg::S_DEQ;
                    end
                    default: begin
                        state_next = (stat.empty || stat.tgt_zero)
                                   ? tqc_pkg::S_RESP : tqc_pkg::S_SEARCH;
                    end
                endcase
            end
            tqc_pkg::S_DEQ: begin
                state_next = tqc_pkg::S_RESP;
            end
            tqc_pkg::S_SEARCH: begin
                if (stat.tag_match || stat.search_last) begin
                    state_next = tqc_pkg::S_RESP;
                end
            end
            tqc_pkg::S_RESP: begin
                if (stat.out_free) begin
                    state_next = tqc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tqc_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        ctrl          = '0;
        ctrl.rd_sel   = tqc_pkg::RD_CUR;
        ctrl.res_kind = tqc_pkg::RK_EMPTY;
        in_ready      = 1'b0;
        unique case (state_reg)
            tqc_pkg::S_IDLE: begin
                in_ready   = 1'b1;
                ctrl.latch = in_valid;
            end
            tqc_pkg::S_DISPATCH: begin
                unique case (stat.cmd)
                    tqc_pkg::CMD_ENQ: begin
                        ctrl.res_load = 1'b1;
                        if (stat.pay_zero) begin
                            ctrl.res_kind = tqc_pkg::RK_ZERO;
                        end else if (stat.full) begin
                            ctrl.res_kind = tqc_pkg::RK_FULL;
                        end else begin
                            ctrl.res_kind = tqc_pkg::RK_ENQ;
                            ctrl.do_enq   = 1'b1;
                        end
                    end
                    tqc_pkg::CMD_DEQ: begin
                        if (stat.empty) begin
                            ctrl.res_load = 1'b1;
                        end else begin
                            ctrl.rd_en  = 1'b1;
                            ctrl.rd_sel = tqc_pkg::RD_HEAD;
                        end
                    end
                    default: begin
                        if (stat.empty || stat.tgt_zero) begin
                            ctrl.res_load = 1'b1;
                        end else begin
                            ctrl.rd_en    = 1'b1;
                            ctrl.rd_sel   = tqc_pkg::RD_TAIL;
                            ctrl.step_clr = 1'b1;
                        end
                    end
                endcase
            end
            tqc_pkg::S_DEQ: begin
                ctrl.do_unlink = 1'b1;
                ctrl.res_load  = 1'b1;
                ctrl.res_kind  = tqc_pkg::RK_DEQ;
            end
            tqc_pkg::S_SEARCH: begin
                if (stat.tag_match) begin
                    ctrl.res_load = 1'b1;
                    if (stat.cmd == tqc_pkg::CMD_REMOVE) begin
                        ctrl.do_unlink = 1'b1;
                        ctrl.res_kind  = tqc_pkg::RK_REMOVE;
                    end else begin
                        ctrl.res_kind = tqc_pkg::RK_GET;
                    end
                end else if (stat.search_last) begin
                    ctrl.res_load = 1'b1;
                end else begin
                    ctrl.rd_en  = 1'b1;
                    ctrl.rd_sel = tqc_pkg::RD_PREV;
                end
            end
            tqc_pkg::S_RESP: begin
                ctrl.out_load = stat.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tqc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/tagged_queue_with_cancel_core.sv
// Each command is latched, dispatched and answered through the output register; dequeue
// reads the head slot first, and remove and get examine up to 16 entries before answering.
// No new command is accepted until the previous result is loaded for output; the search
// walks the linked slots newest to oldest, one slot memory read per cycle.
// Reset (aresetn, synchronous, active low) empties the queue and restarts tags at 1.
module tagged_queue_with_cancel_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tqc_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tqc_pkg::out_t m_data
);

    tqc_pkg::ctrl_t ctrl;
    tqc_pkg::stat_t stat;

    tqc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .stat     (stat),
        .in_ready (s_ready),
        .ctrl     (ctrl)
    );

    tqc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .ctrl      (ctrl),
        .out_ready (m_ready),
        .stat      (stat),
        .out_data  (m_data),
        .out_valid (m_valid)
    );

    // One command is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a command is in progress");

    // Occupancy never exceeds the queue depth.
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.occupancy <= tqc_pkg::OCC_W'(tqc_pkg::DEPTH)))
        else $error("occupancy above depth");

    // A successful command always reports a real tag.
    a_ok_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == tqc_pkg::ST_OK) |-> (m_data.tag_out != '0))
        else $error("successful result with zero tag");

    // A failed command reports neither tag nor payload.
    a_fail_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != tqc_pkg::ST_OK)
        |-> (m_data.tag_out == '0 && m_data.payload_out == '0))
        else $error("failed result carries tag or payload");

endmodule

FILE: sim/tagged_queue_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the tagged queue, keeps its own copy of the queue
// contents and compares every result transfer with the predicted one.
module tagged_queue_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  tqc_pkg::in_t  s_data,
    input  logic          m_valid,
    input  logic          m_ready,
    input  tqc_pkg::out_t m_data,
    output int            pending,
    output int            fail_count
);

    // One held entry, in queue order from oldest to newest.
    typedef struct packed {
        logic [tqc_pkg::TAG_W-1:0]      tag;
        logic [tqc_pkg::PORT_PAY_W-1:0] word;
    } queued_t;

    localparam logic [tqc_pkg::PORT_PAY_W-1:0] PAY_MASK =
        {tqc_pkg::PORT_PAY_W{1'b1}} >> (tqc_pkg::PORT_PAY_W - tqc_pkg::PAYLOAD_WIDTH);

    queued_t                   held_entries[$];
    logic [tqc_pkg::TAG_W-1:0] last_issued_tag;
    tqc_pkg::out_t             expected_results[$];
    int                        mismatches;

    // Applies one command to the queue copy and returns the result it gives.
    function automatic tqc_pkg::out_t apply_command(tqc_pkg::in_t item);
        tqc_pkg::out_t                  res;
        logic [tqc_pkg::PORT_PAY_W-1:0] word;
        int                             hit;
        res  = '0;
        word = item.payload_in & PAY_MASK;
        hit  = -1;
        case (item.command)
            tqc_pkg::CMD_ENQ: begin
                // A zero payload is rejected before the full check.
                if (word == '0) begin
                    res.status = tqc_pkg::ST_ZERO_PAYLOAD;
                end else if (held_entries.size() >= tqc_pkg::DEPTH) begin
                    res.status = tqc_pkg::ST_FULL;
                end else begin
                    if (last_issued_tag == '0 || last_issued_tag == tqc_pkg::TAG_MAX)
                        last_issued_tag = tqc_pkg::TAG_W'(1);
                    else
                        last_issued_tag = last_issued_tag + tqc_pkg::TAG_W'(1);
                    held_entries.push_back({last_issued_tag, word});
                    res.status  = tqc_pkg::ST_OK;
                    res.tag_out = last_issued_tag;
                end
            end
            tqc_pkg::CMD_DEQ: begin
                if (held_entries.size() == 0) begin
                    res.status = tqc_pkg::ST_NOT_FOUND;
                end else begin
                    res.status      = tqc_pkg::ST_OK;
                    res.tag_out     = held_entries[0].tag;
                    res.payload_out = held_entries[0].word;
                    void'(held_entries.pop_front());
                end
            end
            tqc_pkg::CMD_REMOVE, tqc_pkg::CMD_GET: begin
                // The newest entry holding the tag wins; tag zero never matches.
                if (item.target_tag != '0) begin
                    for (int i = held_entries.size() - 1; i >= 0; i--) begin
                        if (held_entries[i].tag == item.target_tag) begin
                            hit = i;
                            break;
                        end
                    end
                end
                if (hit < 0) begin
                    res.status = tqc_pkg::ST_NOT_FOUND;
                end else begin
                    res.status  = tqc_pkg::ST_OK;
                    res.tag_out = item.target_tag;
                    if (item.command == tqc_pkg::CMD_GET)
                        res.payload_out = held_entries[hit].word;
                    else
                        held_entries.delete(hit);
                end
            end
        endcase
        res.occupancy = tqc_pkg::OCC_W'(held_entries.size());
        return res;
    endfunction

    // Compares one result transfer with the oldest prediction.
    task automatic compare_result(tqc_pkg::out_t got);
        tqc_pkg::out_t want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result transfer with nothing expected: status %0d tag %0d",
                         $realtime, got.status, got.tag_out);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.tag_out !== want.tag_out ||
            got.payload_out !== want.payload_out || got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result mismatch, expected status %0d tag %0d payload %h occ %0d",
                         $realtime, want.status, want.tag_out, want.payload_out,
                         want.occupancy);
                $display("%0t:                  got      status %0d tag %0d payload %h occ %0d",
                         $realtime, got.status, got.tag_out, got.payload_out,
                         got.occupancy);
            end
        end
    endtask

    // Results are checked before the prediction of a same-edge command is queued.
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_entries.delete();
            expected_results.delete();
            last_issued_tag = '0;
        end else begin
            if (m_valid && m_ready)
                compare_result(m_data);
            if (s_valid && s_ready)
                expected_results.push_back(apply_command(s_data));
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

FILE: sim/tb_tagged_queue_with_cancel_core.sv
`timescale 1ns / 1ps

module tb_tagged_queue_with_cancel_core;

    localparam int RANDOM_COMMANDS = 1700;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    tqc_pkg::in_t              s_data;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    tqc_pkg::out_t             m_data;
    int                        pending;
    int                        fail_count;
    int                        stall_left = 0;
    bit                        ready_calm = 1'b0;
    bit                        sender_calm = 1'b0;
    logic [tqc_pkg::TAG_W-1:0] newest_seen = '0;

    tagged_queue_with_cancel_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tagged_queue_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Tags searched for: mostly near the newest tag issued, so most searches hit.
    function automatic logic [tqc_pkg::TAG_W-1:0] pick_target();
        int r;
        int lo;
        r  = $urandom_range(0, 99);
        lo = (newest_seen > 20) ? newest_seen - 20 : 1;
        if (r < 75)
            return tqc_pkg::TAG_W'($urandom_range(newest_seen + 1, lo));
        if (r < 83)
            return '0;
        if (r < 95)
            return tqc_pkg::TAG_W'($urandom());
        return tqc_pkg::TAG_MAX;
    endfunction

    function automatic logic [tqc_pkg::PORT_PAY_W-1:0] pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 10)
            return '1;
        if (r < 14)
            return 1;
        return $urandom();
    endfunction

    // Result side stalls; calm stretches keep m_ready high.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (ready_calm || $urandom_range(0, 99) < 65) begin
            m_ready <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            m_ready <= 1'b0;
        end
    end

    // Track the newest tag handed out so searches can aim at live entries.
    always @(posedge aclk) begin
        if (m_valid && m_ready && m_data.status == tqc_pkg::ST_OK &&
            m_data.tag_out > newest_seen)
            newest_seen <= m_data.tag_out;
    end

    // One command transfer, after an optional idle gap on the input side.
    task automatic send_command(tqc_pkg::cmd_t c, logic [tqc_pkg::PORT_PAY_W-1:0] p,
                                logic [tqc_pkg::TAG_W-1:0] t);
        tqc_pkg::in_t item;
        int           gap;
        item.command    = c;
        item.payload_in = p;
        item.target_tag = t;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold off the input side until every predicted result has been seen.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int            seg_left;
        int            enq_pct;
        int            r;
        tqc_pkg::cmd_t c;

        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue, zero payload, extremes, middle and tail removal.
        send_command(tqc_pkg::CMD_DEQ, $urandom(), tqc_pkg::TAG_W'(1));
        send_command(tqc_pkg::CMD_REMOVE, $urandom(), tqc_pkg::TAG_W'(1));
        send_command(tqc_pkg::CMD_GET, $urandom(), tqc_pkg::TAG_W'(1));
        send_command(tqc_pkg::CMD_ENQ, '0, tqc_pkg::TAG_MAX);
        send_command(tqc_pkg::CMD_ENQ, '1, tqc_pkg::TAG_W'(1));
        send_command(tqc_pkg::CMD_ENQ, 1, tqc_pkg::TAG_W'(1));
        send_command(tqc_pkg::CMD_ENQ, 32'h8000_0000, '0);
        send_command(tqc_pkg::CMD_GET, '1, tqc_pkg::TAG_W'(2));
        send_command(tqc_pkg::CMD_GET, $urandom(), '0);
        send_command(tqc_pkg::CMD_GET, $urandom(), tqc_pkg::TAG_MAX);
        send_command(tqc_pkg::CMD_REMOVE, $urandom(), tqc_pkg::TAG_W'(2));
        send_command(tqc_pkg::CMD_GET, $urandom(), tqc_pkg::TAG_W'(2));
        send_command(tqc_pkg::CMD_REMOVE, $urandom(), '0);
        send_command(tqc_pkg::CMD_REMOVE, $urandom(), tqc_pkg::TAG_W'(3));
        send_command(tqc_pkg::CMD_ENQ, 32'h5A5A_5A5A, 31'h2AAA_AAAA);
        send_command(tqc_pkg::CMD_DEQ, $urandom(), 31'h5555_5555);
        send_command(tqc_pkg::CMD_DEQ, $urandom(), tqc_pkg::TAG_W'(4));
        send_command(tqc_pkg::CMD_DEQ, $urandom(), tqc_pkg::TAG_W'(1));
        wait_for_results();

        // Random: segments that fill, balance or drain the queue; the first one
        // fills so the full case comes early.
        seg_left = 40;
        enq_pct  = 85;
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 150);
                r = $urandom_range(0, 2);
                enq_pct = (r == 0) ? 75 : (r == 1) ? 45 : 15;
                sender_calm = ($urandom_range(0, 4) == 0);
                ready_calm <= ($urandom_range(0, 4) == 0);
            end
            seg_left--;
            if (n == RANDOM_COMMANDS / 2)
                wait_for_results();
            if ($urandom_range(0, 99) < enq_pct) begin
                c = tqc_pkg::CMD_ENQ;
            end else begin
                r = $urandom_range(0, 2);
                c = (r == 0) ? tqc_pkg::CMD_DEQ
                  : (r == 1) ? tqc_pkg::CMD_REMOVE : tqc_pkg::CMD_GET;
            end
            send_command(c, pick_payload(), pick_target());
        end

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog for a hung handshake or a lost result.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
